FILE: src/jpr_pkg.sv
// Package: types, phase codes, event codes and receive windows of the J1850 pulse receiver.
package jpr_pkg;

    localparam int unsigned WIDTH_W = 15;

    localparam logic [WIDTH_W-1:0] W_MAX = 15'h7FFF;

    localparam logic [3:0] PH_SOF_0   = 4'd0;
    localparam logic [3:0] PH_SOF_1   = 4'd1;
    localparam logic [3:0] PH_EOD     = 4'd2;
    localparam logic [3:0] PH_EOF     = 4'd3;
    localparam logic [3:0] PH_BRK_0   = 4'd4;
    localparam logic [3:0] PH_BRK_1   = 4'd5;
    localparam logic [3:0] PH_IFS     = 4'd6;
    localparam logic [3:0] PH_INACT_0 = 4'd7;
    localparam logic [3:0] PH_INACT_1 = 4'd8;
    localparam logic [3:0] PH_ACT_0   = 4'd9;
    localparam logic [3:0] PH_ACT_1   = 4'd10;
    localparam logic [3:0] PH_ABORT   = 4'd11;

    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_DATA  = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;
    localparam logic [1:0] EV_ABORT = 2'd3;

    localparam logic MODE_VPW = 1'b0;
    localparam logic MODE_PWM = 1'b1;

    localparam logic [0:0] ADDR_BUS_MODE = 1'b0;

    // PWM windows
    localparam logic [WIDTH_W-1:0] PWM_A_BRK_LO  = 15'd35;
    localparam logic [WIDTH_W-1:0] PWM_A_BRK_HI  = 15'd43;
    localparam logic [WIDTH_W-1:0] PWM_A_SOF_LO  = 15'd27;
    localparam logic [WIDTH_W-1:0] PWM_A_SOF_HI  = 15'd34;
    localparam logic [WIDTH_W-1:0] PWM_LONG_LO   = 15'd12;
    localparam logic [WIDTH_W-1:0] PWM_LONG_HI   = 15'd18;
    localparam logic [WIDTH_W-1:0] PWM_SHORT_LO  = 15'd4;
    localparam logic [WIDTH_W-1:0] PWM_SHORT_HI  = 15'd10;
    localparam logic [WIDTH_W-1:0] PWM_P_BRK_LO  = 15'd3;
    localparam logic [WIDTH_W-1:0] PWM_P_BRK_HI  = 15'd21;
    localparam logic [WIDTH_W-1:0] PWM_P_IFS_LO  = 15'd84;
    localparam logic [WIDTH_W-1:0] PWM_P_SOF_LO  = 15'd11;
    localparam logic [WIDTH_W-1:0] PWM_P_SOF_HI  = 15'd20;
    localparam logic [WIDTH_W-1:0] PWM_P_EOF_LO  = 15'd63;

    // VPW windows
    localparam logic [WIDTH_W-1:0] VPW_A_BRK_LO  = 15'd238;
    localparam logic [WIDTH_W-1:0] VPW_A_SOF_LO  = 15'd163;
    localparam logic [WIDTH_W-1:0] VPW_A_SOF_HI  = 15'd239;
    localparam logic [WIDTH_W-1:0] VPW_LONG_LO   = 15'd96;
    localparam logic [WIDTH_W-1:0] VPW_LONG_HI   = 15'd163;
    localparam logic [WIDTH_W-1:0] VPW_SHORT_LO  = 15'd34;
    localparam logic [WIDTH_W-1:0] VPW_SHORT_HI  = 15'd96;
    localparam logic [WIDTH_W-1:0] VPW_P_IFS_LO  = 15'd280;
    localparam logic [WIDTH_W-1:0] VPW_P_EOF_LO  = 15'd239;
    localparam logic [WIDTH_W-1:0] VPW_P_EOD_LO  = 15'd163;
    localparam logic [WIDTH_W-1:0] VPW_P_EOD_HI  = 15'd239;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } t_event;

    typedef struct packed {
        logic [1:0] count;
        t_event     ev0;
        t_event     ev1;
    } t_step_ev;

    function automatic logic win(input logic [WIDTH_W-1:0] w,
                                 input logic [WIDTH_W-1:0] lo,
                                 input logic [WIDTH_W-1:0] hi);
        return (w >= lo) && (w <= hi);
    endfunction

endpackage

FILE: src/jpr_if.sv
// Interfaces: pulse input channel and event output channel.
interface jpr_pulse_if import jpr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [WIDTH_W-1:0] pulse_width_us;
    logic               pulse_level;

    modport source(output valid, output pulse_width_us, output pulse_level, input ready);
    modport sink(input valid, input pulse_width_us, input pulse_level, output ready);
endinterface

interface jpr_event_if import jpr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] data_byte;
    logic       last;

    modport source(output valid, output event_kind, output data_byte, output last,
                   input ready);
    modport sink(input valid, input event_kind, input data_byte, input last, output ready);
endinterface

FILE: src/jpr_frame.sv
// Frame tracker: window classification, phase register, bit shifter and event generation.
module jpr_frame import jpr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_bus_mode,
    input  logic [WIDTH_W-1:0] i_width,
    input  logic               i_level,
    output t_step_ev           o_ev
);

    logic [3:0] r_phase, n_phase;
    logic [7:0] r_shifter, n_shifter;
    logic [3:0] r_held, n_held;
    logic       r_prev;

    logic       waiting;
    logic [3:0] ph0;
    logic [3:0] held0;
    logic [3:0] ph1;
    logic [3:0] held_inc;
    logic       do_shift;
    logic       shift_bit;
    logic       got_byte;
    logic       term;
    logic [1:0] term_kind;
    logic       in_inact;
    t_event     ev_start, ev_byte, ev_term;

    always_comb begin
        waiting   = (r_phase == PH_SOF_1);
        ph0       = waiting ? PH_ACT_0 : r_phase;
        held0     = waiting ? 4'd0 : r_held;
        in_inact  = (ph0 == PH_INACT_0) || (ph0 == PH_INACT_1);
        ph1       = ph0;
        do_shift  = 1'b0;
        shift_bit = 1'b0;

        if (i_level != r_prev) begin
            if (i_bus_mode == MODE_PWM) begin
                if (i_level) begin
                    if (win(i_width, PWM_A_BRK_LO, PWM_A_BRK_HI)) begin
                        ph1 = PH_BRK_0;
                    end else if (win(i_width, PWM_A_SOF_LO, PWM_A_SOF_HI)) begin
                        ph1 = waiting ? PH_SOF_0 : PH_ABORT;
                    end else if (win(i_width, PWM_LONG_LO, PWM_LONG_HI)) begin
                        ph1 = PH_INACT_0;
                    end else if (win(i_width, PWM_SHORT_LO, PWM_SHORT_HI)) begin
                        ph1 = PH_INACT_1;
                    end else begin
                        ph1 = PH_ABORT;
                    end
                end else begin
                    if (ph0 == PH_BRK_0 && win(i_width, PWM_P_BRK_LO, PWM_P_BRK_HI)) begin
                        ph1 = PH_IFS;
                    end else if (ph0 == PH_IFS && win(i_width, PWM_P_IFS_LO, W_MAX)) begin
                        ph1 = PH_SOF_1;
                    end else if (ph0 == PH_SOF_0 && win(i_width, PWM_P_SOF_LO, PWM_P_SOF_HI)) begin
                        ph1 = PH_ACT_0;
                    end else if (ph0 == PH_INACT_0 && win(i_width, PWM_SHORT_LO, PWM_SHORT_HI)) begin
                        do_shift = 1'b1;
                    end else if (ph0 == PH_INACT_1 && win(i_width, PWM_LONG_LO, PWM_LONG_HI)) begin
                        do_shift  = 1'b1;
                        shift_bit = 1'b1;
                    end else if (in_inact && win(i_width, PWM_P_EOF_LO, W_MAX)) begin
                        ph1 = (held0 != 4'd0) ? PH_ABORT : PH_EOF;
                    end else begin
                        ph1 = PH_ABORT;
                    end
                end
            end else begin
                if (i_level) begin
                    if (win(i_width, VPW_A_BRK_LO, W_MAX)) begin
                        ph1 = PH_IFS;
                    end else if (win(i_width, VPW_A_SOF_LO, VPW_A_SOF_HI)) begin
                        ph1 = waiting ? PH_INACT_0 : PH_ABORT;
                    end else if (win(i_width, VPW_LONG_LO, VPW_LONG_HI)) begin
                        ph1      = PH_INACT_0;
                        do_shift = 1'b1;
                    end else if (win(i_width, VPW_SHORT_LO, VPW_SHORT_HI)) begin
                        ph1       = PH_INACT_1;
                        do_shift  = 1'b1;
                        shift_bit = 1'b1;
                    end else begin
                        ph1 = PH_ABORT;
                    end
                end else begin
                    if (ph0 == PH_IFS && win(i_width, VPW_P_IFS_LO, W_MAX)) begin
                        ph1 = PH_SOF_1;
                    end else if (win(i_width, VPW_SHORT_LO, VPW_SHORT_HI)) begin
                        ph1      = PH_ACT_0;
                        do_shift = 1'b1;
                    end else if (win(i_width, VPW_LONG_LO, VPW_LONG_HI)) begin
                        ph1       = PH_ACT_1;
                        do_shift  = 1'b1;
                        shift_bit = 1'b1;
                    end else if (in_inact) begin
                        if (held0 != 4'd0) begin
                            ph1 = PH_ABORT;
                        end else if (win(i_width, VPW_P_EOF_LO, W_MAX)) begin
                            ph1 = PH_EOF;
                        end else if (win(i_width, VPW_P_EOD_LO, VPW_P_EOD_HI)) begin
                            ph1 = PH_EOD;
                        end else begin
                            ph1 = PH_ABORT;
                        end
                    end else begin
                        ph1 = PH_ABORT;
                    end
                end
            end
        end

        // shift in the new bit, MSB first
        held_inc  = held0 + 4'd1;
        got_byte  = do_shift && (held_inc == 4'd8);
        n_shifter = do_shift ? {r_shifter[6:0], shift_bit} : r_shifter;
        n_held    = do_shift ? (got_byte ? 4'd0 : held_inc) : held0;
        n_phase   = ph1;
        term      = 1'b0;
        term_kind = EV_END;

        if (ph1 == PH_EOD || ph1 == PH_EOF) begin
            term      = 1'b1;
            term_kind = EV_END;
            n_phase   = PH_SOF_1;
        end else if (ph1 == PH_ABORT) begin
            term      = 1'b1;
            term_kind = EV_ABORT;
            n_phase   = PH_SOF_1;
            n_held    = 4'd0;
        end

        ev_start = '{kind: EV_START, data: 8'd0, last: !term};
        ev_byte  = '{kind: EV_DATA, data: n_shifter, last: !term};
        ev_term  = '{kind: term_kind, data: 8'd0, last: 1'b1};

        // a start and a byte never coincide: a start clears the held bits
        o_ev.ev0   = ev_term;
        o_ev.ev1   = ev_term;
        o_ev.count = {1'b0, term};
        if (waiting) begin
            o_ev.ev0   = ev_start;
            o_ev.count = term ? 2'd2 : 2'd1;
        end else if (got_byte) begin
            o_ev.ev0   = ev_byte;
            o_ev.count = term ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SOF_1;
            r_shifter <= 8'd0;
            r_held    <= 4'd0;
            r_prev    <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_shifter <= n_shifter;
            r_held    <= n_held;
            r_prev    <= i_level;
        end
    end

endmodule

FILE: src/jpr_evbuf.sv
// Result buffer: holds up to two events of one pulse and hands them out one per transfer.
module jpr_evbuf import jpr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_step_ev i_ev,
    output logic     o_free,
    jpr_event_if.source o_event
);

    logic [1:0] r_cnt, n_cnt;
    t_event     r_ev0, n_ev0;
    t_event     r_ev1, n_ev1;
    logic       out_xfer;

    assign out_xfer = o_event.valid && o_event.ready;
    assign o_free   = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_xfer);

    always_comb begin
        n_cnt = r_cnt;
        n_ev0 = r_ev0;
        n_ev1 = r_ev1;
        if (i_load) begin
            n_cnt = i_ev.count;
            n_ev0 = i_ev.ev0;
            n_ev1 = i_ev.ev1;
        end else if (out_xfer) begin
            n_cnt = r_cnt - 2'd1;
            n_ev0 = r_ev1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev0 <= n_ev0;
        r_ev1 <= n_ev1;
    end

    assign o_event.valid      = (r_cnt != 2'd0);
    assign o_event.event_kind = r_ev0.kind;
    assign o_event.data_byte  = r_ev0.data;
    assign o_event.last       = r_ev0.last;

endmodule

FILE: src/j1850_pulse_receiver.sv
// J1850 VPW/PWM pulse receiver top level: input register, configuration port, frame tracker, result buffer.
//
// Each accepted pulse (width in us, level) is held in the input register, classified against
// the receive windows of the selected timing (bus_mode: 0 VPW, 1 PWM, APB offset 0), and its
// events (frame start, data byte, frame end, frame aborted) are loaded into a two-entry result
// buffer, which registers them. A new pulse is taken every cycle as long as the results drain:
// a pulse that gives two results occupies the output for two transfers, so the sustained rate
// is one pulse per cycle for pulses with at most one result, while a pulse with two results
// holds off the next pulse with results until its second result is being taken. Pulses with
// no result pass through without touching the output.
module j1850_pulse_receiver import jpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jpr_pulse_if.sink   i_pulse,
    jpr_event_if.source o_event,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic               r_in_valid;
    logic [WIDTH_W-1:0] r_width;
    logic               r_level;
    logic               r_bus_mode;
    logic               in_xfer;
    logic               step;
    logic               buf_free;
    t_step_ev           step_ev;

    assign in_xfer       = i_pulse.valid && i_pulse.ready;
    assign step          = r_in_valid && ((step_ev.count == 2'd0) || buf_free);
    assign i_pulse.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_width <= i_pulse.pulse_width_us;
            r_level <= i_pulse.pulse_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_mode <= MODE_VPW;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_BUS_MODE) begin
            r_bus_mode <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BUS_MODE) ? {31'd0, r_bus_mode} : 32'd0;

    jpr_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_bus_mode (r_bus_mode),
        .i_width    (r_width),
        .i_level    (r_level),
        .o_ev       (step_ev)
    );

    jpr_evbuf u_evbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && (step_ev.count != 2'd0)),
        .i_ev    (step_ev),
        .o_free  (buf_free),
        .o_event (o_event)
    );

endmodule

FILE: src/jpr_checker.sv
// Port checker for the J1850 pulse receiver, bound to the top level.
module jpr_checker import jpr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [7:0]  out_byte,
    input logic        out_last,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [0:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
            && $stable(out_last))
        else $error("stalled result changed");

    a_byte_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_kind != EV_DATA |-> out_byte == 8'd0)
        else $error("non-data event carries a byte");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && !out_last |=> out_valid)
        else $error("second result of a pulse missing");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr == ADDR_BUS_MODE
            |=> paddr != ADDR_BUS_MODE || prdata[0] == $past(pwdata[0]))
        else $error("bus_mode readback mismatch");

endmodule

bind j1850_pulse_receiver jpr_checker u_jpr_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .out_valid (o_event.valid),
    .out_ready (o_event.ready),
    .out_kind  (o_event.event_kind),
    .out_byte  (o_event.data_byte),
    .out_last  (o_event.last),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

FILE: dv/jpr_event_checker.sv
// Event checker: watches the pulse, event and register ports, predicts each pulse's events and compares.
module jpr_event_checker import jpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jpr_pulse_if        pulse_mon,
    jpr_event_if        event_mon,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [0:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_pulses,
    output int          o_results,
    output int          o_bytes,
    output int          o_ends,
    output int          o_aborts
);

    logic       mode_q;
    logic [3:0] phase_q;
    logic [7:0] shifter_q;
    logic [3:0] held_q;
    logic       level_q;

    t_event     pulse_events[2];
    int         pulse_event_cnt;
    t_event     awaited_events[$];

    int err_count    = 0;
    int queued       = 0;
    int pulse_count  = 0;
    int result_count = 0;
    int byte_count   = 0;
    int end_count    = 0;
    int abort_count  = 0;

    assign o_errors  = err_count;
    assign o_pending = queued;
    assign o_pulses  = pulse_count;
    assign o_results = result_count;
    assign o_bytes   = byte_count;
    assign o_ends    = end_count;
    assign o_aborts  = abort_count;

    function automatic bit fits(input logic [14:0] w, input int lo, input int hi);
        return int'(w) >= lo && int'(w) <= hi;
    endfunction

    task automatic note(input logic [1:0] kind, input logic [7:0] data);
        if (pulse_event_cnt < 2) begin
            pulse_events[pulse_event_cnt] = '{kind: kind, data: data, last: 1'b0};
            pulse_event_cnt++;
        end
    endtask

    task automatic shift_in(input logic b);
        shifter_q = {shifter_q[6:0], b};
        held_q    = held_q + 4'd1;
        if (held_q == 4'd8) begin
            note(EV_DATA, shifter_q);
            held_q = '0;
        end
    endtask

    task automatic close_gap(input bit matched, input logic [3:0] kind);
        phase_q = (!matched || held_q != 0) ? PH_ABORT : kind;
    endtask

    task automatic decode_pulse(input logic [14:0] w, input logic lvl);
        bit         waiting;
        logic [3:0] ph;
        t_event     ev;
        pulse_event_cnt = 0;
        waiting = (phase_q == PH_SOF_1);
        if (waiting) begin
            note(EV_START, 8'h00);
            phase_q = PH_ACT_0;
            held_q  = '0;
        end
        ph = phase_q;
        if (lvl != level_q) begin
            if (mode_q == MODE_PWM) begin
                if (lvl) begin
                    if (fits(w, 35, 43))      phase_q = PH_BRK_0;
                    else if (fits(w, 27, 34)) phase_q = waiting ? PH_SOF_0 : PH_ABORT;
                    else if (fits(w, 12, 18)) phase_q = PH_INACT_0;
                    else if (fits(w, 4, 10))  phase_q = PH_INACT_1;
                    else                      phase_q = PH_ABORT;
                end else begin
                    if (ph == PH_BRK_0 && fits(w, 3, 21))           phase_q = PH_IFS;
                    else if (ph == PH_IFS && fits(w, 84, 32767))    phase_q = PH_SOF_1;
                    else if (ph == PH_SOF_0 && fits(w, 11, 20))     phase_q = PH_ACT_0;
                    else if (ph == PH_INACT_0 && fits(w, 4, 10))    shift_in(1'b0);
                    else if (ph == PH_INACT_1 && fits(w, 12, 18))   shift_in(1'b1);
                    else if ((ph == PH_INACT_0 || ph == PH_INACT_1) && fits(w, 63, 32767))
                        close_gap(1'b1, PH_EOF);
                    else
                        phase_q = PH_ABORT;
                end
            end else begin
                if (lvl) begin
                    if (fits(w, 238, 32767)) begin
                        phase_q = PH_IFS;
                    end else if (fits(w, 163, 239)) begin
                        phase_q = waiting ? PH_INACT_0 : PH_ABORT;
                    end else if (fits(w, 96, 163)) begin
                        phase_q = PH_INACT_0;
                        shift_in(1'b0);
                    end else if (fits(w, 34, 96)) begin
                        phase_q = PH_INACT_1;
                        shift_in(1'b1);
                    end else begin
                        phase_q = PH_ABORT;
                    end
                end else begin
                    if (ph == PH_IFS && fits(w, 280, 32767)) begin
                        phase_q = PH_SOF_1;
                    end else if (fits(w, 34, 96)) begin
                        phase_q = PH_ACT_0;
                        shift_in(1'b0);
                    end else if (fits(w, 96, 163)) begin
                        phase_q = PH_ACT_1;
                        shift_in(1'b1);
                    end else if (ph == PH_INACT_0 || ph == PH_INACT_1) begin
                        if (fits(w, 239, 32767))    close_gap(1'b1, PH_EOF);
                        else if (fits(w, 163, 239)) close_gap(1'b1, PH_EOD);
                        else                        close_gap(1'b0, PH_ABORT);
                    end else begin
                        phase_q = PH_ABORT;
                    end
                end
            end
        end
        level_q = lvl;
        if (phase_q == PH_EOD || phase_q == PH_EOF) begin
            note(EV_END, 8'h00);
            phase_q = PH_SOF_1;
        end else if (phase_q == PH_ABORT) begin
            note(EV_ABORT, 8'h00);
            phase_q = PH_SOF_1;
            held_q  = '0;
        end
        for (int k = 0; k < pulse_event_cnt; k++) begin
            ev      = pulse_events[k];
            ev.last = (k == pulse_event_cnt - 1);
            awaited_events.push_back(ev);
        end
    endtask

    always @(posedge i_clk) begin
        t_event seen;
        t_event want;
        if (!i_rst_n) begin
            mode_q    = MODE_VPW;
            phase_q   = PH_SOF_1;
            shifter_q = '0;
            held_q    = '0;
            level_q   = 1'b0;
            awaited_events.delete();
        end else begin
            if (event_mon.valid && event_mon.ready) begin
                seen = '{kind: event_mon.event_kind, data: event_mon.data_byte,
                         last: event_mon.last};
                result_count++;
                case (seen.kind)
                    EV_DATA:  byte_count++;
                    EV_END:   end_count++;
                    EV_ABORT: abort_count++;
                    default: ;
                endcase
                if (awaited_events.size() == 0) begin
                    $display({"%0t: unexpected result: expected none, ",
                              "got kind %0d byte 0x%02h last %0d"},
                             $time, seen.kind, seen.data, seen.last);
                    err_count++;
                end else begin
                    want = awaited_events.pop_front();
                    if (seen.kind !== want.kind || seen.data !== want.data
                            || seen.last !== want.last) begin
                        $display({"%0t: result mismatch: expected kind %0d byte 0x%02h ",
                                  "last %0d, got kind %0d byte 0x%02h last %0d"},
                                 $time, want.kind, want.data, want.last,
                                 seen.kind, seen.data, seen.last);
                        err_count++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_BUS_MODE)
                mode_q = i_pwdata[0];
            if (pulse_mon.valid && pulse_mon.ready) begin
                pulse_count++;
                decode_pulse(pulse_mon.pulse_width_us, pulse_mon.pulse_level);
            end
        end
        queued <= awaited_events.size();
    end

endmodule

FILE: dv/j1850_pulse_receiver_tb.sv
// Testbench top: clock, reset, pulse stimulus, register writes, event stalls and the verdict.
module j1850_pulse_receiver_tb;
    import jpr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_PULSES  = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending, pulses, results, bytes_seen, ends_seen, aborts_seen;

    int   send_idle_pct  = 0;
    int   stall_pct      = 0;
    int   cycle_count    = 0;
    int   changed_pulses = 0;
    int   frame_pos      = 0;
    bit   synced         = 1'b1;
    logic sent_level     = 1'b0;
    logic cur_mode       = MODE_VPW;

    jpr_pulse_if pulse_if ();
    jpr_event_if event_if ();

    j1850_pulse_receiver u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pulse (pulse_if),
        .o_event (event_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    jpr_event_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .pulse_mon (pulse_if),
        .event_mon (event_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_pready  (pready),
        .o_errors  (errors),
        .o_pending (pending),
        .o_pulses  (pulses),
        .o_results (results),
        .o_bytes   (bytes_seen),
        .o_ends    (ends_seen),
        .o_aborts  (aborts_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        event_if.ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still awaited", $time, pending);
            $display("j1850_pulse_receiver_tb: FAIL");
            $finish;
        end
    end

    function automatic int span(input int lo, input int hi);
        int r;
        r = $urandom_range(9, 0);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(hi, lo);
    endfunction

    function automatic int open_span(input int lo);
        int r;
        r = $urandom_range(9, 0);
        if (r == 0) return lo;
        if (r == 1) return 32767;
        return lo + $urandom_range(400, 0);
    endfunction

    task automatic put(input int w, input logic lvl);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            pulse_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pulse_if.valid          <= 1'b1;
        pulse_if.pulse_width_us <= w[14:0];
        pulse_if.pulse_level    <= lvl;
        @(posedge i_clk);
        while (!pulse_if.ready) @(posedge i_clk);
        if (lvl != sent_level) changed_pulses++;
        sent_level = lvl;
    endtask

    // hold off until every predicted result has been transferred
    task automatic settle();
        pulse_if.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BUS_MODE;
        pwdata  <= {31'($urandom()), mode};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_mode = mode;
    endtask

    task automatic frame_put(input int w, input logic lvl, input int bad_at);
        if (frame_pos == bad_at) put($urandom_range(400, 0), lvl);
        else put(w, lvl);
        frame_pos++;
    endtask

    task automatic send_frame(input int nbits, input logic [23:0] payload, input int bad_at);
        logic b;
        frame_pos = 0;
        if (cur_mode == MODE_PWM) begin
            frame_put(span(27, 34), 1'b1, bad_at);
            frame_put(span(11, 20), 1'b0, bad_at);
            for (int i = 0; i < nbits; i++) begin
                b = payload[nbits-1-i];
                frame_put(b ? span(4, 10) : span(12, 18), 1'b1, bad_at);
                frame_put(b ? span(12, 18) : span(4, 10), 1'b0, bad_at);
            end
            frame_put($urandom_range(1, 0) ? span(4, 10) : span(12, 18), 1'b1, bad_at);
            frame_put(open_span(63), 1'b0, bad_at);
        end else begin
            frame_put(span(163, 237), 1'b1, bad_at);
            for (int i = 0; i < nbits; i++) begin
                b = payload[nbits-1-i];
                if (i % 2 == 0) frame_put(b ? span(97, 163) : span(34, 96), 1'b0, bad_at);
                else            frame_put(b ? span(34, 95) : span(96, 162), 1'b1, bad_at);
            end
            frame_put($urandom_range(1, 0) ? open_span(239) : span(164, 238), 1'b0, bad_at);
        end
    endtask

    // abort from any phase, then leave the block waiting with the passive level
    task automatic resync();
        if (sent_level) put($urandom_range(2, 0), 1'b0);
        put($urandom_range(2, 0), 1'b1);
        put($urandom_range(2, 0), 1'b0);
        synced = 1'b1;
    endtask

    task automatic send_break();
        if (sent_level) put($urandom_range(400, 0), 1'b0);
        if (cur_mode == MODE_PWM) begin
            put(span(35, 43), 1'b1);
            put(span(3, 21), 1'b0);
            synced = 1'b0;
        end else begin
            put(open_span(238), 1'b1);
            put(open_span(280), 1'b0);
            synced = 1'b1;
        end
    endtask

    task automatic random_unit();
        int r;
        int nbits;
        r = $urandom_range(99, 0);
        if (r < 55) begin
            if (!synced) resync();
            send_frame(8 * $urandom_range(3, 0), 24'($urandom()), -1);
        end else if (r < 65) begin
            send_break();
        end else if (r < 80) begin
            if (!synced) resync();
            if ($urandom_range(1, 0)) begin
                if (cur_mode == MODE_PWM)
                    nbits = 8 * $urandom_range(2, 0) + $urandom_range(7, 1);
                else
                    nbits = 8 * $urandom_range(2, 0) + 2 * $urandom_range(3, 1);
                send_frame(nbits, 24'($urandom()), -1);
            end else begin
                send_frame(8 * $urandom_range(2, 1), 24'($urandom()), $urandom_range(20, 0));
            end
            synced = 1'b0;
        end else begin
            repeat ($urandom_range(4, 1))
                put($urandom_range(1, 0) ? $urandom_range(32767, 0) : $urandom_range(400, 0),
                    $urandom_range(1, 0));
            synced = 1'b0;
        end
    endtask

    initial begin
        int target;
        i_rst_n                 <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= ADDR_BUS_MODE;
        pwdata                  <= '0;
        pulse_if.valid          <= 1'b0;
        pulse_if.pulse_width_us <= '0;
        pulse_if.pulse_level    <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // VPW after reset: one clean byte, break extremes, repeated level, SOF inside a frame
        send_frame(8, 24'h0000A5, -1);
        put(32767, 1'b1);
        put(32767, 1'b0);
        put(0, 1'b0);
        put(200, 1'b1);

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_mode(MODE_PWM);
        // PWM: passive while waiting, partial byte at frame end, break
        put(0, 1'b0);
        send_frame(1, 24'h000001, -1);
        put(43, 1'b1);
        put(3, 1'b0);
        synced = 1'b0;

        for (int ph = 0; ph < 8; ph++) begin
            settle();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            write_mode((ph % 2 == 0) ? MODE_VPW : MODE_PWM);
            synced = 1'b0;
            case (ph / 2)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            target = changed_pulses + PHASE_PULSES;
            while (changed_pulses < target) begin
                random_unit();
                if ($urandom_range(49, 0) == 0) settle();
            end
        end

        settle();
        repeat (SETTLE_CYCLES + 4) @(posedge i_clk);
        $display("covered %0d pulses over VPW and PWM timing with idle and stall mixes",
                 pulses);
        $display("checked %0d results: %0d data bytes, %0d frame ends, %0d aborts",
                 results, bytes_seen, ends_seen, aborts_seen);
        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (errors == 0 && pending == 0)
            $display("j1850_pulse_receiver_tb: PASS");
        else
            $display("j1850_pulse_receiver_tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
src/jpr_pkg.sv
src/jpr_if.sv
src/jpr_frame.sv
src/jpr_evbuf.sv
src/j1850_pulse_receiver.sv
src/jpr_checker.sv
dv/jpr_event_checker.sv
dv/j1850_pulse_receiver_tb.sv
